// ===== rtl/ffh_pkg.sv =====
// ----------------------------------------------------------------------------
// ffh_pkg
// Types, codes and sizes shared by the fault-formation height map block.
// ----------------------------------------------------------------------------
package ffh_pkg;

  localparam int MAX_SIZE_DEF    = 256;
  localparam int HEIGHT_BITS_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GRID_W     = 9;
  localparam int ITER_W     = 11;
  localparam int COEFF_W    = 16;
  localparam int HCFG_W     = 32;
  localparam int COORD_W    = 8;
  // fault counter times (max - min): 12-bit signed times 33-bit signed
  localparam int PROD_W     = ITER_W + 1 + HCFG_W + 1;

  typedef enum logic [1:0] {
    CMD_FAULT  = 2'd0,
    CMD_SMOOTH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_EQUAL   = 2'd1,
    STS_EXHAUST = 2'd2,
    STS_RANGE   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE  = 3'd0,
    REG_ITER_COUNT = 3'd1,
    REG_MIN_HEIGHT = 3'd2,
    REG_MAX_HEIGHT = 3'd3,
    REG_FILT_COEFF = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_RDATA
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_z;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_z;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] cell_height;
  } out_t;

  typedef struct packed {
    logic                      smooth;
    logic [COEFF_W-1:0]        coeff;
    logic signed [HCFG_W-1:0]  fault_h;
  } alu_ctl_t;

endpackage

// ===== rtl/ffh_ram.sv =====
// ----------------------------------------------------------------------------
// ffh_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ffh_div.sv =====
// ----------------------------------------------------------------------------
// ffh_div
// Serial signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ffh_div #(
  parameter int DW = 44,
  parameter int VW = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [DW:0]  dividend,
  input  logic [VW-1:0]       divisor,
  output logic                done,
  output logic signed [DW:0]  quot
);

  localparam int CNT_W = $clog2(DW);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DW-1:0]     quo_r;
  logic [VW:0]       rem_r;
  logic [VW-1:0]     dvs_r;
  logic [DW:0]       mag;
  logic [VW:0]       rem_sh;
  logic              fits;

  assign mag    = dividend[DW] ? (DW+1)'(-dividend) : dividend;
  assign rem_sh = {rem_r[VW-1:0], quo_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(DW - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(DW - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DW];
      quo_r <= mag[DW-1:0];
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[DW-2:0], fits};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

// ===== rtl/ffh_alu.sv =====
// ----------------------------------------------------------------------------
// ffh_alu
// Cell update: saturating fault add, or one-pole blend rounded half up.
// ----------------------------------------------------------------------------
module ffh_alu #(
  parameter int HEIGHT_BITS = ffh_pkg::HEIGHT_BITS_DEF
) (
  input  ffh_pkg::alu_ctl_t              ctl,
  input  logic signed [HEIGHT_BITS-1:0]  cur,
  input  logic signed [HEIGHT_BITS-1:0]  prev,
  output logic signed [HEIGHT_BITS-1:0]  res
);

  localparam int HB = HEIGHT_BITS;
  localparam int SW = ((HB > ffh_pkg::HCFG_W) ? HB : ffh_pkg::HCFG_W) + 1;
  localparam int PW = HB + 1 + ffh_pkg::COEFF_W + 1;
  localparam logic signed [SW-1:0] HMAX = {{(SW-HB+1){1'b0}}, {(HB-1){1'b1}}};
  localparam logic signed [SW-1:0] HMIN = ~HMAX;

  logic signed [SW-1:0] sum;
  logic signed [HB:0]   d;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [HB-1:0] sat;
  logic signed [HB-1:0] blend;

  always_comb begin
    sum = SW'(cur) + SW'(ctl.fault_h);
    if (sum > HMAX) begin
      sat = HB'(HMAX);
    end else if (sum < HMIN) begin
      sat = HB'(HMIN);
    end else begin
      sat = HB'(sum);
    end
    d     = (HB+1)'(prev) - (HB+1)'(cur);
    prod  = d * $signed({1'b0, ctl.coeff});
    rnd   = (prod + PW'(32768)) >>> 16;
    blend = cur + HB'(rnd);
    res   = ctl.smooth ? blend : sat;
  end

endmodule

// ===== rtl/fault_formation_heightmap_top.sv =====
// ----------------------------------------------------------------------------
// fault_formation_heightmap_top
// Fault-formation height map held in one RAM. Fault, smooth and clear commands
// sweep the grid (clear: all of RAM) one cell per cycle; read fetches one cell.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid/in_stall     | ffh_pkg::in_t (command, points)
//  out_    | output    | out_valid/out_stall   | ffh_pkg::out_t (status, height)
//  cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// Command steps: fault runs multiply, height divide, sweep and drain. Smooth
// runs four sweep passes, one RAM read and at most one write per cycle, each
// blended cell feeding the next. Read runs read, data and drain. Clear sweeps
// all of RAM, then drains. A rejected fault or read goes straight to drain.
// After reset a clearing pass over the whole RAM runs with in_stall high.
// in_stall is low only when idle; a result waits in the output register.
// ----------------------------------------------------------------------------
module fault_formation_heightmap_top #(
  parameter int MAX_SIZE    = ffh_pkg::MAX_SIZE_DEF,
  parameter int HEIGHT_BITS = ffh_pkg::HEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ffh_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ffh_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [ffh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int XW = $clog2(MAX_SIZE);
  localparam int NW = XW + 1;
  localparam int AW = 2 * XW;
  localparam int HB = HEIGHT_BITS;
  localparam int CW = NW + 2;
  localparam int PW = ffh_pkg::PROD_W;
  localparam int HW = ffh_pkg::HCFG_W;

  // configuration
  logic [ffh_pkg::GRID_W-1:0]  grid_r;
  logic [ffh_pkg::ITER_W-1:0]  iter_r;
  logic signed [HW-1:0]        minh_r;
  logic signed [HW-1:0]        maxh_r;
  logic [ffh_pkg::COEFF_W-1:0] coeff_r;

  ffh_pkg::state_t state_r, state_nxt;
  ffh_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [ffh_pkg::COORD_W-1:0] x1_r, x1_nxt, z1_r, z1_nxt, x2_r, x2_nxt, z2_r, z2_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [1:0]      pass_r, pass_nxt;
  logic [XW-1:0]   a_r, a_nxt, k_r, k_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            resp_pend_r, resp_pend_nxt;
  logic            s1_v_r, s1_v_nxt, s1_first_r, s1_first_nxt, s1_hit_r, s1_hit_nxt;
  logic [AW-1:0]   s1_addr_r, s1_addr_nxt;
  logic signed [HB-1:0] prev_r, prev_nxt;
  logic signed [HW-1:0] h_r, h_nxt;
  logic [ffh_pkg::ITER_W-1:0] fcnt_r, fcnt_nxt;
  ffh_pkg::status_t status_r, status_nxt;
  logic signed [31:0]   resph_r, resph_nxt;
  logic            out_valid_r, out_valid_nxt;
  ffh_pkg::out_t   out_r, out_nxt;

  // shared combinational signals
  logic [NW-1:0]   n_now;
  logic [11:0]     grid12;
  ffh_pkg::status_t chk_status;
  logic            accept;
  logic            k_last, a_last, p_last, sweep_last;
  logic [XW-1:0]   sx, sz;
  logic [NW-1:0]   k_rev;
  logic signed [CW-1:0] xs, zs, x1s, z1s, dxs, dzs;
  logic signed [2*CW-1:0] m1, m2;
  logic signed [2*CW:0]   cp;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [HB-1:0]   rd_data;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [HB-1:0]   ram_wdata;
  logic signed [HB-1:0] alu_res;
  ffh_pkg::alu_ctl_t alu_ctl;
  logic            div_start, div_done;
  logic signed [PW-1:0] div_quot;
  logic signed [HW:0]   hdiff;
  logic signed [PW-1:0] prod;
  logic signed [63:0]   cell64;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r  <= ffh_pkg::GRID_W'(256);
      iter_r  <= ffh_pkg::ITER_W'(50);
      minh_r  <= '0;
      maxh_r  <= HW'(3276800);
      coeff_r <= ffh_pkg::COEFF_W'(13107);
    end else if (cfg_we) begin
      case (cfg_index)
        ffh_pkg::REG_GRID_SIZE:  grid_r  <= cfg_data[ffh_pkg::GRID_W-1:0];
        ffh_pkg::REG_ITER_COUNT: iter_r  <= cfg_data[ffh_pkg::ITER_W-1:0];
        ffh_pkg::REG_MIN_HEIGHT: minh_r  <= $signed(cfg_data[HW-1:0]);
        ffh_pkg::REG_MAX_HEIGHT: maxh_r  <= $signed(cfg_data[HW-1:0]);
        ffh_pkg::REG_FILT_COEFF: coeff_r <= cfg_data[ffh_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  always_comb begin
    grid12 = 12'(grid_r);
    if (grid12 > 12'(MAX_SIZE)) begin
      n_now = NW'(MAX_SIZE);
    end else if (grid12 < 12'd2) begin
      n_now = NW'(2);
    end else begin
      n_now = NW'(grid_r);
    end
  end

  always_comb begin
    chk_status = ffh_pkg::STS_OK;
    if (12'(in_data.first_x) >= 12'(n_now) || 12'(in_data.first_z) >= 12'(n_now)) begin
      chk_status = ffh_pkg::STS_RANGE;
    end else if (in_data.command == ffh_pkg::CMD_FAULT) begin
      if (12'(in_data.second_x) >= 12'(n_now) || 12'(in_data.second_z) >= 12'(n_now)) begin
        chk_status = ffh_pkg::STS_RANGE;
      end else if (in_data.first_x == in_data.second_x &&
                   in_data.first_z == in_data.second_z) begin
        chk_status = ffh_pkg::STS_EQUAL;
      end else if (fcnt_r >= iter_r) begin
        chk_status = ffh_pkg::STS_EXHAUST;
      end
    end
  end

  assign in_stall = (state_r != ffh_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------- sweep
  always_comb begin
    k_last     = (NW'(k_r) == n_r - NW'(1));
    a_last     = (NW'(a_r) == n_r - NW'(1));
    p_last     = (cmd_r == ffh_pkg::CMD_FAULT) || (pass_r == 2'd3);
    sweep_last = k_last && a_last && p_last;
    k_rev      = n_r - NW'(1) - NW'(k_r);
    case (pass_r)
      2'd0:    begin sx = k_r;            sz = a_r;            end
      2'd1:    begin sx = k_rev[XW-1:0];  sz = a_r;            end
      2'd2:    begin sx = a_r;            sz = k_r;            end
      default: begin sx = a_r;            sz = k_rev[XW-1:0];  end
    endcase
    xs  = $signed(CW'(sx));
    zs  = $signed(CW'(sz));
    x1s = $signed(CW'(x1_r));
    z1s = $signed(CW'(z1_r));
    dxs = $signed(CW'(x2_r)) - x1s;
    dzs = $signed(CW'(z2_r)) - z1s;
    m1  = (xs - x1s) * dzs;
    m2  = dxs * (zs - z1s);
    cp  = (2*CW+1)'(m1) - (2*CW+1)'(m2);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {sz, sx};
    if (state_r == ffh_pkg::ST_SWEEP) begin
      rd_en = 1'b1;
    end else if (state_r == ffh_pkg::ST_READ) begin
      rd_en   = 1'b1;
      rd_addr = {XW'(z1_r), XW'(x1_r)};
    end
  end

  // ---------------------------------------------------------------- datapath
  assign alu_ctl.smooth  = (cmd_r == ffh_pkg::CMD_SMOOTH);
  assign alu_ctl.coeff   = coeff_r;
  assign alu_ctl.fault_h = h_r;

  ffh_alu #(.HEIGHT_BITS(HB)) u_alu (
    .ctl  (alu_ctl),
    .cur  ($signed(rd_data)),
    .prev (prev_r),
    .res  (alu_res)
  );

  assign ram_we = (state_r == ffh_pkg::ST_CLEAR) ||
                  (s1_v_r && (alu_ctl.smooth ? !s1_first_r : s1_hit_r));
  assign ram_waddr = (state_r == ffh_pkg::ST_CLEAR) ? clr_r : s1_addr_r;
  assign ram_wdata = (state_r == ffh_pkg::ST_CLEAR) ? '0 : alu_res;

  ffh_ram #(.WIDTH(HB), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign hdiff     = (HW+1)'(maxh_r) - (HW+1)'(minh_r);
  assign prod      = $signed({1'b0, fcnt_r}) * hdiff;
  assign div_start = (state_r == ffh_pkg::ST_MUL);

  ffh_div #(.DW(PW - 1), .VW(ffh_pkg::ITER_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (iter_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign cell64 = 64'($signed(rd_data));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffh_pkg::ST_CLEAR: begin
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = resp_pend_r ? ffh_pkg::ST_DRAIN : ffh_pkg::ST_IDLE;
        end
      end
      ffh_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            ffh_pkg::CMD_FAULT:
              state_nxt = (chk_status == ffh_pkg::STS_OK) ? ffh_pkg::ST_MUL
                                                          : ffh_pkg::ST_DRAIN;
            ffh_pkg::CMD_SMOOTH: state_nxt = ffh_pkg::ST_SWEEP;
            ffh_pkg::CMD_READ:
              state_nxt = (chk_status == ffh_pkg::STS_OK) ? ffh_pkg::ST_READ
                                                          : ffh_pkg::ST_DRAIN;
            default: state_nxt = ffh_pkg::ST_CLEAR;
          endcase
        end
      end
      ffh_pkg::ST_MUL:   state_nxt = ffh_pkg::ST_DIV;
      ffh_pkg::ST_DIV:   if (div_done) state_nxt = ffh_pkg::ST_SWEEP;
      ffh_pkg::ST_SWEEP: if (sweep_last) state_nxt = ffh_pkg::ST_DRAIN;
      ffh_pkg::ST_READ:  state_nxt = ffh_pkg::ST_RDATA;
      ffh_pkg::ST_RDATA: state_nxt = ffh_pkg::ST_DRAIN;
      ffh_pkg::ST_DRAIN: begin
        // hold the result until the output register frees up
        if (!s1_v_r && (!out_valid_r || !out_stall)) begin
          state_nxt = ffh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffh_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    x1_nxt        = x1_r;
    z1_nxt        = z1_r;
    x2_nxt        = x2_r;
    z2_nxt        = z2_r;
    n_nxt         = n_r;
    pass_nxt      = pass_r;
    a_nxt         = a_r;
    k_nxt         = k_r;
    clr_nxt       = clr_r;
    resp_pend_nxt = resp_pend_r;
    s1_v_nxt      = 1'b0;
    s1_first_nxt  = (k_r == '0);
    s1_hit_nxt    = !cp[2*CW] && (cp != '0);
    s1_addr_nxt   = rd_addr;
    prev_nxt      = prev_r;
    h_nxt         = h_r;
    fcnt_nxt      = fcnt_r;
    status_nxt    = status_r;
    resph_nxt     = resph_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    if (s1_v_r && alu_ctl.smooth) begin
      prev_nxt = s1_first_r ? $signed(rd_data) : alu_res;
    end

    case (state_r)
      ffh_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
      end
      ffh_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_data.command;
          x1_nxt        = in_data.first_x;
          z1_nxt        = in_data.first_z;
          x2_nxt        = in_data.second_x;
          z2_nxt        = in_data.second_z;
          n_nxt         = n_now;
          pass_nxt      = '0;
          a_nxt         = '0;
          k_nxt         = '0;
          clr_nxt       = '0;
          resp_pend_nxt = 1'b1;
          resph_nxt     = '0;
          status_nxt    = ffh_pkg::STS_OK;
          if (in_data.command == ffh_pkg::CMD_FAULT ||
              in_data.command == ffh_pkg::CMD_READ) begin
            status_nxt = chk_status;
          end
          if (in_data.command == ffh_pkg::CMD_CLEAR) begin
            fcnt_nxt = '0;
          end
        end
      end
      ffh_pkg::ST_DIV: begin
        if (div_done) begin
          h_nxt    = HW'(maxh_r - HW'(div_quot));
          fcnt_nxt = fcnt_r + ffh_pkg::ITER_W'(1);
        end
      end
      ffh_pkg::ST_SWEEP: begin
        s1_v_nxt = 1'b1;
        // advance along the line, then to the next line, then the next pass
        if (k_last) begin
          k_nxt = '0;
          if (a_last) begin
            a_nxt    = '0;
            pass_nxt = pass_r + 2'd1;
          end else begin
            a_nxt = a_r + XW'(1);
          end
        end else begin
          k_nxt = k_r + XW'(1);
        end
      end
      ffh_pkg::ST_RDATA: begin
        resph_nxt = cell64[31:0];
      end
      ffh_pkg::ST_DRAIN: begin
        if (!s1_v_r && (!out_valid_r || !out_stall)) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = status_r;
          out_nxt.cell_height   = resph_r;
          resp_pend_nxt         = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffh_pkg::ST_CLEAR;
      clr_r       <= '0;
      resp_pend_r <= 1'b0;
      s1_v_r      <= 1'b0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      resp_pend_r <= resp_pend_nxt;
      s1_v_r      <= s1_v_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    x1_r       <= x1_nxt;
    z1_r       <= z1_nxt;
    x2_r       <= x2_nxt;
    z2_r       <= z2_nxt;
    n_r        <= n_nxt;
    pass_r     <= pass_nxt;
    a_r        <= a_nxt;
    k_r        <= k_nxt;
    s1_first_r <= s1_first_nxt;
    s1_hit_r   <= s1_hit_nxt;
    s1_addr_r  <= s1_addr_nxt;
    prev_r     <= prev_nxt;
    h_r        <= h_nxt;
    status_r   <= status_nxt;
    resph_r    <= resph_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffh_pkg::ST_IDLE |-> !ram_we)
    else $error("height store written while idle");

  a_stage_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(state_r) == ffh_pkg::ST_SWEEP)
    else $error("update stage active without a sweep read");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ffh_pkg::STS_OK |-> out_r.cell_height == 32'sd0)
    else $error("rejected beat carries a height");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fault-formation height map: directed commands
// and register extremes, then random command streams under several idling
// modes, each reply checked against an in-bench model of the height store.
// ----------------------------------------------------------------------------
module tb;

  localparam int      EDGE        = 256;
  localparam longint  CYCLE_LIMIT = 20000000;
  localparam longint  HMAX        = 64'sd2147483647;
  localparam longint  HMIN        = -64'sd2147483648;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  ffh_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ffh_pkg::out_t                  out_data;
  logic                           cfg_we = 1'b0;
  logic [ffh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ffh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fault_formation_heightmap_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state and register copies
  longint      heights [EDGE*EDGE];
  int unsigned fault_cnt;
  int unsigned m_grid, m_iter, m_coeff;
  longint      m_min, m_max;

  ffh_pkg::in_t   cmd_queue [$];
  ffh_pkg::out_t  expected_replies [$];
  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    hold_req = 0;
  int    fails = 0;
  int    beats_checked = 0;
  int    faults_applied = 0;
  int    rejects = 0;
  longint cycles = 0;

  initial forever #4 clk = ~clk;

  function automatic int unsigned grid_in_use();
    if (m_grid > EDGE) return EDGE;
    if (m_grid < 2) return 2;
    return m_grid;
  endfunction

  function automatic longint blend(longint p, longint c);
    longint d, dl, dh, lo;
    d  = p - c;
    dl = d & 64'hFFFF;
    dh = (d - dl) / 65536;
    lo = (dl * longint'(m_coeff) + 32768) >>> 16;
    return c + dh * longint'(m_coeff) + lo;
  endfunction

  function automatic void smooth_grid(int n);
    longint p;
    for (int a = 0; a < n; a++) begin
      p = heights[a*EDGE];
      for (int b = 1; b < n; b++) begin
        heights[a*EDGE+b] = blend(p, heights[a*EDGE+b]); p = heights[a*EDGE+b];
      end
    end
    for (int a = 0; a < n; a++) begin
      p = heights[a*EDGE+n-1];
      for (int b = n-2; b >= 0; b--) begin
        heights[a*EDGE+b] = blend(p, heights[a*EDGE+b]); p = heights[a*EDGE+b];
      end
    end
    for (int a = 0; a < n; a++) begin
      p = heights[a];
      for (int b = 1; b < n; b++) begin
        heights[b*EDGE+a] = blend(p, heights[b*EDGE+a]); p = heights[b*EDGE+a];
      end
    end
    for (int a = 0; a < n; a++) begin
      p = heights[(n-1)*EDGE+a];
      for (int b = n-2; b >= 0; b--) begin
        heights[b*EDGE+a] = blend(p, heights[b*EDGE+a]); p = heights[b*EDGE+a];
      end
    end
  endfunction

  function automatic ffh_pkg::status_t apply_fault(int x1, int z1, int x2, int z2, int n);
    longint h, v;
    int dx, dz, cp;
    if (x1 >= n || z1 >= n || x2 >= n || z2 >= n) return ffh_pkg::STS_RANGE;
    if (x1 == x2 && z1 == z2) return ffh_pkg::STS_EQUAL;
    if (fault_cnt >= m_iter) return ffh_pkg::STS_EXHAUST;
    h  = m_max - (longint'(fault_cnt) * (m_max - m_min)) / longint'(m_iter);
    dx = x2 - x1;
    dz = z2 - z1;
    for (int z = 0; z < n; z++)
      for (int x = 0; x < n; x++) begin
        cp = (x - x1) * dz - dx * (z - z1);
        if (cp > 0) begin
          v = heights[z*EDGE+x] + h;
          if (v > HMAX) v = HMAX;
          if (v < HMIN) v = HMIN;
          heights[z*EDGE+x] = v;
        end
      end
    fault_cnt = (fault_cnt + 1) & 11'h7FF;
    faults_applied++;
    return ffh_pkg::STS_OK;
  endfunction

  function automatic ffh_pkg::out_t predict_reply(ffh_pkg::in_t it);
    ffh_pkg::out_t r;
    int n;
    n = grid_in_use();
    r = '0;
    r.status = ffh_pkg::STS_OK;
    case (it.command)
      ffh_pkg::CMD_FAULT:
        r.status = apply_fault(int'(it.first_x), int'(it.first_z),
                               int'(it.second_x), int'(it.second_z), n);
      ffh_pkg::CMD_SMOOTH: smooth_grid(n);
      ffh_pkg::CMD_READ: begin
        if (int'(it.first_x) >= n || int'(it.first_z) >= n) r.status = ffh_pkg::STS_RANGE;
        else r.cell_height = heights[int'(it.first_z)*EDGE + int'(it.first_x)][31:0];
      end
      default: begin
        foreach (heights[i]) heights[i] = 0;
        fault_cnt = 0;
      end
    endcase
    return r;
  endfunction

  // driver: present the head of the queue, hold it while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(predict_reply(in_data));
        void'(cmd_queue.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= cmd_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted down in cycles
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each reply beat
  always @(posedge clk) begin
    if (out_valid && !out_stall && rst_n) begin
      if (expected_replies.size() == 0) begin
        $error("reply beat with nothing expected: status %0d height %0d",
               out_data.status, out_data.cell_height);
        fails++;
      end else begin
        ffh_pkg::out_t e;
        e = expected_replies.pop_front();
        if (e.status !== out_data.status) begin
          $error("status: expected %0d actual %0d", e.status, out_data.status);
          fails++;
        end
        if (e.cell_height !== out_data.cell_height) begin
          $error("cell_height: expected %0d actual %0d", e.cell_height, out_data.cell_height);
          fails++;
        end
        if (e.status != ffh_pkg::STS_OK) rejects++;
        beats_checked++;
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(ffh_pkg::reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      ffh_pkg::REG_GRID_SIZE:  m_grid  = v & 32'h1FF;
      ffh_pkg::REG_ITER_COUNT: m_iter  = v & 32'h7FF;
      ffh_pkg::REG_MIN_HEIGHT: m_min   = longint'($signed(v));
      ffh_pkg::REG_MAX_HEIGHT: m_max   = longint'($signed(v));
      default:                 m_coeff = v & 32'hFFFF;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_queue.size() != 0 || expected_replies.size() != 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic ffh_pkg::in_t mk(ffh_pkg::cmd_t c, int x1, int z1, int x2, int z2);
    ffh_pkg::in_t it;
    it.command  = c;
    it.first_x  = ffh_pkg::COORD_W'(x1);
    it.first_z  = ffh_pkg::COORD_W'(z1);
    it.second_x = ffh_pkg::COORD_W'(x2);
    it.second_z = ffh_pkg::COORD_W'(z2);
    return it;
  endfunction

  function automatic ffh_pkg::in_t random_cmd(int n);
    int r, lim;
    ffh_pkg::in_t it;
    r = $urandom_range(99);
    // mostly coordinates inside the grid, some full-range noise
    lim = ($urandom_range(99) < 75) ? n - 1 : 255;
    it = mk(ffh_pkg::CMD_FAULT, $urandom_range(lim), $urandom_range(lim),
            $urandom_range(lim), $urandom_range(lim));
    if (r < 2) it.command = ffh_pkg::CMD_CLEAR;
    else if (r < 15) it.command = ffh_pkg::CMD_SMOOTH;
    else if (r < 45) it.command = ffh_pkg::CMD_READ;
    else if (r < 50) begin
      it.second_x = it.first_x;
      it.second_z = it.first_z;
    end
    return it;
  endfunction

  task automatic random_settings();
    int g;
    g = $urandom_range(2, 16);
    if ($urandom_range(9) == 0) g = $urandom_range(0, 1);
    write_reg(ffh_pkg::REG_GRID_SIZE, g);
    write_reg(ffh_pkg::REG_ITER_COUNT,
              ($urandom_range(9) == 0) ? 1024 : $urandom_range(1, 40));
    write_reg(ffh_pkg::REG_MIN_HEIGHT, $urandom);
    write_reg(ffh_pkg::REG_MAX_HEIGHT, $urandom);
    write_reg(ffh_pkg::REG_FILT_COEFF, $urandom_range(32'h0000_FFFF));
    end_writes();
  endtask

  initial begin
    m_grid = 256; m_iter = 50; m_min = 0; m_max = 3276800; m_coeff = 13107;
    fault_cnt = 0;
    foreach (heights[i]) heights[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, full grid
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 0, 0, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 0, 0, 255, 255));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 7, 9, 7, 9));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 0, 255, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 255, 0, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_SMOOTH, 0, 0, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 255, 255, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 3, 200, 0, 0));
    drain();

    // small grid, saturating heights, full-weight smoothing
    write_reg(ffh_pkg::REG_GRID_SIZE, 8);
    write_reg(ffh_pkg::REG_ITER_COUNT, 3);
    write_reg(ffh_pkg::REG_MIN_HEIGHT, 32'h8000_0000);
    write_reg(ffh_pkg::REG_MAX_HEIGHT, 32'h7FFF_FFFF);
    write_reg(ffh_pkg::REG_FILT_COEFF, 32'h0000_FFFF);
    end_writes();
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 8, 0, 1, 1));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 0, 0, 1, 255));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 2, 2, 2, 2));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 0, 7, 7, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 7, 7, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 0, 3, 7, 4));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 1, 1, 6, 6));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 0, 7, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 8, 0, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_SMOOTH, 0, 0, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 7, 0, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_CLEAR, 0, 0, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 7, 0, 0, 0));
    drain();

    // grid below the minimum, zero count, zero weight
    write_reg(ffh_pkg::REG_GRID_SIZE, 0);
    write_reg(ffh_pkg::REG_ITER_COUNT, 0);
    write_reg(ffh_pkg::REG_FILT_COEFF, 0);
    end_writes();
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 0, 0, 1, 1));
    cmd_queue.push_back(mk(ffh_pkg::CMD_FAULT, 2, 0, 1, 1));
    cmd_queue.push_back(mk(ffh_pkg::CMD_SMOOTH, 0, 0, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 1, 1, 0, 0));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 0, 2, 0, 0));
    drain();

    // grid above the maximum is clamped; reads only
    write_reg(ffh_pkg::REG_GRID_SIZE, 511);
    end_writes();
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 255, 255, 255, 255));
    cmd_queue.push_back(mk(ffh_pkg::CMD_READ, 200, 100, 0, 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      random_settings();
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 78) : 0;
      stall_pct     = (ph == 2) ? 78 : ((ph == 3) ? 38 : 0);
      // long receiver hold-off while the sender keeps offering
      if (ph == 0) hold_req++;
      for (int k = 0; k < 18; k++) cmd_queue.push_back(random_cmd(grid_in_use()));
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (100) @(posedge clk);

    $display("checked %0d reply beats: %0d faults applied, %0d rejected commands",
             beats_checked, faults_applied, rejects);
    $display("covered register extremes, clamped grids and four idling modes");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ffh_pkg.sv
rtl/ffh_ram.sv
rtl/ffh_div.sv
rtl/ffh_alu.sv
rtl/fault_formation_heightmap_top.sv
tb/sv/tb.sv
